FILE: hdl/ast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_pkg
// Shared constants, codes and helpers for the array stack with neighbor search.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IO_W       = 32;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_PRED  = 3'd4,
    REQ_SUCC  = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NO_PRED   = 3'd3,
    ST_NO_SUCC   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_RESP
  } state_t;

  // input value -> stored word (sign-extend, then keep DATA_WIDTH bits)
  function automatic word_t to_word(input logic [IO_W-1:0] v);
    logic signed [63:0] t;
    t = 64'(signed'(v));
    return t[DATA_WIDTH-1:0];
  endfunction

  // stored word -> output data (sign-extend, then keep IO_W bits)
  function automatic logic [IO_W-1:0] to_data(input word_t w);
    logic signed [63:0] t;
    t = 64'(signed'(w));
    return t[IO_W-1:0];
  endfunction

endpackage

FILE: hdl/ast_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/array_stack_with_neighbor_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_stack_with_neighbor_search
// LIFO stack in a synchronous RAM with predecessor and successor search.
// ----------------------------------------------------------------------------
// One request is worked at a time, one result per request. Push, clear and
// unused codes go from idle straight to the result state; pop and peek pass
// through the read state first; a search walks the RAM downward from the top,
// one entry per cycle through its single read port, and reads the neighbor of
// a hit through the read state. A new request is taken once the previous result
// sits in the output register, even if it has not yet been transferred out.
// ----------------------------------------------------------------------------
module array_stack_with_neighbor_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] data,
  output logic [2:0]  status,
  output logic        is_empty
);

  ast_pkg::state_t  state, state_next;
  ast_pkg::cnt_t    fill, fill_next;
  ast_pkg::ptr_t    idx, idx_next;
  ast_pkg::req_t    req, req_next;
  ast_pkg::word_t   key, key_next;
  logic [ast_pkg::IO_W-1:0] res_data, res_data_next;
  ast_pkg::status_t res_status, res_status_next;

  logic          rd_en, wr_en, load_out;
  ast_pkg::ptr_t rd_addr, wr_addr;
  ast_pkg::word_t wr_data, rd_data;

  logic accept, full, empty, hit, slot_free;

  assign accept    = in_valid && in_ready;
  assign full      = (fill == ast_pkg::CNT_W'(ast_pkg::DEPTH));
  assign empty     = (fill == '0);
  assign hit       = (rd_data == key);
  assign slot_free = !out_valid || out_ready;

  ast_ram #(
    .WIDTH (ast_pkg::DATA_WIDTH),
    .DEPTH (ast_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ast_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            ast_pkg::REQ_POP, ast_pkg::REQ_PEEK: begin
              state_next = empty ? ast_pkg::S_RESP : ast_pkg::S_READ;
            end
            ast_pkg::REQ_PRED, ast_pkg::REQ_SUCC: begin
              state_next = empty ? ast_pkg::S_RESP : ast_pkg::S_SCAN;
            end
            default: state_next = ast_pkg::S_RESP;
          endcase
        end
      end
      ast_pkg::S_READ: state_next = ast_pkg::S_RESP;
      ast_pkg::S_SCAN: begin
        if (hit) begin
          if (req == ast_pkg::REQ_PRED) begin
            state_next = (idx == '0) ? ast_pkg::S_RESP : ast_pkg::S_READ;
          end else begin
            state_next = ((ast_pkg::CNT_W'(idx) + 1'b1) >= fill) ?
                         ast_pkg::S_RESP : ast_pkg::S_READ;
          end
        end else if (idx == '0) begin
          state_next = ast_pkg::S_RESP;
        end
      end
      ast_pkg::S_RESP: begin
        if (slot_free) state_next = ast_pkg::S_IDLE;
      end
      default: state_next = ast_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    in_ready        = (state == ast_pkg::S_IDLE);
    rd_en           = 1'b0;
    rd_addr         = idx;
    wr_en           = 1'b0;
    wr_addr         = fill[ast_pkg::PTR_W-1:0];
    wr_data         = ast_pkg::to_word(value);
    load_out        = 1'b0;
    fill_next       = fill;
    idx_next        = idx;
    req_next        = req;
    key_next        = key;
    res_data_next   = res_data;
    res_status_next = res_status;
    unique case (state)
      ast_pkg::S_IDLE: begin
        if (accept) begin
          req_next        = ast_pkg::req_t'(req_type);
          key_next        = ast_pkg::to_word(value);
          res_data_next   = '0;
          res_status_next = ast_pkg::ST_OK;
          idx_next        = ast_pkg::PTR_W'(fill - 1'b1);
          unique case (req_type)
            ast_pkg::REQ_PUSH: begin
              if (full) begin
                res_status_next = ast_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                fill_next = fill + 1'b1;
              end
            end
            ast_pkg::REQ_POP, ast_pkg::REQ_PEEK: begin
              if (empty) begin
                res_status_next = ast_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = ast_pkg::PTR_W'(fill - 1'b1);
                if (req_type == ast_pkg::REQ_POP) fill_next = fill - 1'b1;
              end
            end
            ast_pkg::REQ_CLEAR: fill_next = '0;
            ast_pkg::REQ_PRED, ast_pkg::REQ_SUCC: begin
              if (empty) begin
                res_status_next = ast_pkg::ST_NOT_FOUND;
              end else begin
                rd_en   = 1'b1;
                rd_addr = ast_pkg::PTR_W'(fill - 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      ast_pkg::S_READ: begin
        res_data_next = ast_pkg::to_data(rd_data);
      end
      ast_pkg::S_SCAN: begin
        if (hit) begin
          if (req == ast_pkg::REQ_PRED) begin
            if (idx == '0) begin
              res_status_next = ast_pkg::ST_NO_PRED;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx - 1'b1;
            end
          end else begin
            if ((ast_pkg::CNT_W'(idx) + 1'b1) >= fill) begin
              res_status_next = ast_pkg::ST_NO_SUCC;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx + 1'b1;
            end
          end
        end else if (idx == '0) begin
          res_status_next = ast_pkg::ST_NOT_FOUND;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx - 1'b1;
          idx_next = idx - 1'b1;
        end
      end
      ast_pkg::S_RESP: load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ast_pkg::S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    req        <= req_next;
    key        <= key_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
    if (load_out) begin
      data     <= res_data;
      status   <= res_status;
      is_empty <= empty;
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LIFO stack with neighbor search.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel. A behavioral stack model in the
// bench predicts the data, status and empty flag of each request when it is
// transferred, and the output monitor compares every result against the
// oldest prediction. Directed tests cover the empty and full corners and the
// search edge cases. Three random phases then drive the stack around: mixed,
// push-heavy toward full, and one with few pushes. Both sides stall at
// random, except in one long stretch.
// ----------------------------------------------------------------------------
module tb;
  import ast_pkg::*;

  localparam logic [2:0] REQ_RSVD_6  = 3'd6;
  localparam logic [2:0] REQ_RSVD_7  = 3'd7;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         POOL_SIZE   = 12;

  typedef struct {
    logic [31:0] data;
    status_t     status;
    logic        is_empty;
  } stack_resp_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  req_type;
  logic [31:0] value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] data;
  logic [2:0]  status;
  logic        is_empty;

  word_t       stack_mem [DEPTH];
  int          stack_fill;
  stack_resp_t pending_resps [$];
  logic [31:0] key_pool [POOL_SIZE];
  int          mismatches;
  bit          no_stall;
  int          cycle_count;

  array_stack_with_neighbor_search dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data      (data),
    .status    (status),
    .is_empty  (is_empty)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= REQ_PUSH;
    value     <= '0;
    out_ready <= 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= no_stall || ($urandom_range(99) >= 12);
  end

  function automatic logic [31:0] widen_word(word_t w);
    return 32'(signed'(w));
  endfunction

  function automatic stack_resp_t predict_stack_op(logic [2:0] op, logic [31:0] arg);
    stack_resp_t r;
    word_t       key;
    int          hit;
    r.data   = '0;
    r.status = ST_OK;
    key      = word_t'(signed'(arg));
    hit      = -1;
    for (int i = stack_fill - 1; i >= 0; i--) begin
      if (stack_mem[i] == key) begin
        hit = i;
        break;
      end
    end
    case (op)
      REQ_PUSH: begin
        if (stack_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[stack_fill] = key;
          stack_fill++;
        end
      end
      REQ_POP: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_fill--;
          r.data = widen_word(stack_mem[stack_fill]);
        end
      end
      REQ_PEEK: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else r.data = widen_word(stack_mem[stack_fill-1]);
      end
      REQ_CLEAR: stack_fill = 0;
      REQ_PRED: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else if (hit == 0) r.status = ST_NO_PRED;
        else r.data = widen_word(stack_mem[hit-1]);
      end
      REQ_SUCC: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else if (hit + 1 >= stack_fill) r.status = ST_NO_SUCC;
        else r.data = widen_word(stack_mem[hit+1]);
      end
      default: ;
    endcase
    r.is_empty = (stack_fill == 0);
    return r;
  endfunction

  // valid stays high between back-to-back requests; it drops only on random input stalls and in wait_drained
  task automatic send_req(input logic [2:0] op, input logic [31:0] arg);
    while (!no_stall && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= op;
    value    <= arg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_resps.push_back(predict_stack_op(op, arg));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_resps.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    stack_resp_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_resps.size() == 0) begin
        $error("unexpected result transfer: data %h status %0d is_empty %0b",
               data, status, is_empty);
        mismatches++;
      end else begin
        exp_r = pending_resps.pop_front();
        if (exp_r.data !== data) begin
          $error("data: expected %h, got %h", exp_r.data, data);
          mismatches++;
        end
        if (exp_r.status !== status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          mismatches++;
        end
        if (exp_r.is_empty !== is_empty) begin
          $error("is_empty: expected %0b, got %0b", exp_r.is_empty, is_empty);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_corner_cases();
    send_req(REQ_POP,    $urandom);
    send_req(REQ_PEEK,   $urandom);
    send_req(REQ_PRED,   32'h0);
    send_req(REQ_SUCC,   32'h0);
    send_req(REQ_CLEAR,  $urandom);
    send_req(REQ_RSVD_6, $urandom);
    send_req(REQ_RSVD_7, $urandom);
    send_req(REQ_PUSH,   32'h8000_0000);
    send_req(REQ_PUSH,   32'h7FFF_FFFF);
    send_req(REQ_PUSH,   32'h0);
    send_req(REQ_PUSH,   32'hFFFF_FFFF);
    send_req(REQ_PEEK,   $urandom);
    send_req(REQ_PRED,   32'h8000_0000);
    send_req(REQ_SUCC,   32'hFFFF_FFFF);
    send_req(REQ_PRED,   32'h0);
    send_req(REQ_SUCC,   32'h7FFF_FFFF);
    send_req(REQ_SUCC,   32'h8000_0000);
    send_req(REQ_PRED,   32'h0000_3039);
    send_req(REQ_PUSH,   32'h0);
    send_req(REQ_PRED,   32'h0);   // topmost duplicate wins
    send_req(REQ_RSVD_7, $urandom);
    send_req(REQ_POP,    $urandom);
    send_req(REQ_POP,    $urandom);
    send_req(REQ_CLEAR,  $urandom);
  endtask

  task automatic test_full_stack();
    logic [31:0] mid_key;
    wait_drained();
    for (int i = 0; i < DEPTH; i++) begin
      send_req(REQ_PUSH, (i % 3 == 0) ? key_pool[$urandom_range(POOL_SIZE-1)] : $urandom);
    end
    mid_key = widen_word(stack_mem[DEPTH/2]);
    send_req(REQ_PUSH, $urandom);
    send_req(REQ_PEEK, $urandom);
    send_req(REQ_SUCC, mid_key);
    send_req(REQ_PRED, mid_key);
    send_req(REQ_SUCC, widen_word(stack_mem[DEPTH-1]));
    send_req(REQ_PRED, widen_word(stack_mem[0]));
    send_req(REQ_SUCC, widen_word(stack_mem[0]));
    for (int i = 0; i < 8; i++) send_req(REQ_POP, $urandom);
    send_req(REQ_CLEAR, $urandom);
    send_req(REQ_PEEK, $urandom);
  endtask

  task automatic test_random_phase(input int n_items, input int push_pct);
    logic [2:0]  op;
    logic [31:0] arg;
    int          pick;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < push_pct) begin
        op = REQ_PUSH;
      end else begin
        pick = $urandom_range(99);
        if (pick < 30)      op = REQ_POP;
        else if (pick < 45) op = REQ_PEEK;
        else if (pick < 70) op = REQ_PRED;
        else if (pick < 95) op = REQ_SUCC;
        else if (pick < 97) op = REQ_CLEAR;
        else if (pick < 99) op = REQ_RSVD_6;
        else                op = REQ_RSVD_7;
      end
      pick = $urandom_range(99);
      if ((op == REQ_PRED || op == REQ_SUCC) && stack_fill > 0 && pick < 55)
        arg = widen_word(stack_mem[$urandom_range(stack_fill-1)]);
      else if (pick < 80)
        arg = key_pool[$urandom_range(POOL_SIZE-1)];
      else
        arg = $urandom;
      send_req(op, arg);
    end
  endtask

  initial begin
    mismatches = 0;
    no_stall   = 1'b0;
    stack_fill = 0;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_full_stack();
    test_random_phase(250, 45);
    no_stall = 1'b1;
    test_random_phase(250, 80);
    no_stall = 1'b0;
    wait_drained();
    test_random_phase(250, 25);
    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ast_pkg.sv
hdl/ast_ram.sv
hdl/array_stack_with_neighbor_search.sv
verif/tb.sv
